@@ rtl/dact_pkg.sv @@
`default_nettype none

package dact_pkg;

   // default table depth
   localparam int TABLE_ENTRIES_DEF = 192;

   // key field widths
   localparam int PC_W    = 32;
   localparam int ADDR_W  = 32;
   localparam int BYTES_W = 4;
   localparam int KEY_W   = PC_W + ADDR_W + BYTES_W + 1;
   localparam int COUNT_W = 32;
   localparam int SLOT_W  = 8;

   // beat widths
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 48;
   localparam int RSP_USER_W = 2;

   // sequencer states, one-hot
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

endpackage

`default_nettype wire

@@ rtl/distinct_access_counter_table.sv @@
`default_nettype none

// Counts distinct faulted bus accesses. Each request beat carries a key (pc, address,
// byte count, direction); the table is scanned from slot zero, one entry per cycle, out of
// a single table memory with a registered read port. A match bumps that entry's count
// (saturating at all ones), a miss appends the key at the fill level with count one, and a
// miss on a full table is reported as dropped. Each entry is read into a register before
// it is compared; a hit answers once the scan reaches its slot, a miss once it passes the
// fill level, and a done state passes before the next request beat can be taken. The
// response is held in an output register, so a stalled response only blocks once the next
// key has finished its scan. Fill level and control state are reset; no clearing pass.
module distinct_access_counter_table #(
   parameter int TABLE_ENTRIES = dact_pkg::TABLE_ENTRIES_DEF
) (
   input  wire  logic                            clock,
   input  wire  logic                            reset,
   // req_tdata: fault_pc[31:0], access_address[63:32], access_bytes[67:64],
   //            is_write[68], zero fill[71:69]
   input  wire  logic                            req_tvalid,
   output logic                                  req_tready,
   input  wire  logic [dact_pkg::REQ_DATA_W-1:0] req_tdata,
   // rsp_tdata: slot[7:0], hit_count[39:8], distinct_total[47:40]
   // rsp_tuser: is_new[0], dropped[1]
   output logic                                  rsp_tvalid,
   input  wire  logic                            rsp_tready,
   output logic [dact_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   output logic [dact_pkg::RSP_USER_W-1:0]       rsp_tuser
);
   import dact_pkg::*;

   localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CW = $clog2(TABLE_ENTRIES + 1);
   localparam int XW = (CW > SLOT_W) ? CW : SLOT_W;
   localparam int WORD_W = COUNT_W + KEY_W;

   // table memory: {count, key}
   logic [WORD_W-1:0] table_mem [TABLE_ENTRIES];

   state_type          state_ff, state_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [CW-1:0]      cmp_idx_ff, cmp_idx_in;
   logic               cmp_vld_ff, cmp_vld_in;
   logic [CW-1:0]      fill_ff, fill_in;
   logic [WORD_W-1:0]  rd_data_ff;

   logic               rsp_vld_ff, rsp_vld_in;
   logic               rsp_new_ff, rsp_new_in;
   logic               rsp_drop_ff, rsp_drop_in;
   logic [SLOT_W-1:0]  rsp_slot_ff, rsp_slot_in;
   logic [COUNT_W-1:0] rsp_cnt_ff, rsp_cnt_in;
   logic [SLOT_W-1:0]  rsp_total_ff, rsp_total_in;

   logic               req_beat, rsp_free;
   logic               hit, miss, done, commit, full;
   logic               rd_en, wr_en;
   logic [IW-1:0]      wr_addr;
   logic [WORD_W-1:0]  wr_data;
   logic [COUNT_W-1:0] rd_cnt, inc_cnt;
   logic [XW-1:0]      cmp_idx_x, fill_x, fill_inc_x;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_beat   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_vld_ff || rsp_tready;

   // compare stage on the registered entry
   assign rd_cnt  = rd_data_ff[WORD_W-1 -: COUNT_W];
   assign inc_cnt = (rd_cnt == {COUNT_W{1'b1}}) ? rd_cnt : rd_cnt + COUNT_W'(1);
   assign hit     = (state_ff == ST_SCAN) && cmp_vld_ff && (rd_data_ff[KEY_W-1:0] == key_ff);
   assign miss    = (state_ff == ST_SCAN) && !hit && (idx_ff >= fill_ff);
   assign done    = hit || miss;
   assign commit  = done && rsp_free;
   assign full    = (fill_ff >= CW'(TABLE_ENTRIES));
   assign rd_en   = (state_ff == ST_SCAN) && !done;

   assign cmp_idx_x  = XW'(cmp_idx_ff);
   assign fill_x     = XW'(fill_ff);
   assign fill_inc_x = XW'(fill_ff) + XW'(1);

   // table write: count update on a hit, append on a miss with room
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = fill_ff[IW-1:0];
      wr_data = {COUNT_W'(1), key_ff};
      if (commit && hit) begin
         wr_en   = 1'b1;
         wr_addr = cmp_idx_ff[IW-1:0];
         wr_data = {inc_cnt, key_ff};
      end else if (commit && !full) begin
         wr_en = 1'b1;
      end
   end

   // sequencer and response register
   always_comb begin
      state_in     = state_ff;
      key_in       = key_ff;
      idx_in       = idx_ff;
      cmp_idx_in   = cmp_idx_ff;
      cmp_vld_in   = cmp_vld_ff;
      fill_in      = fill_ff;
      rsp_vld_in   = rsp_vld_ff && !rsp_tready;
      rsp_new_in   = rsp_new_ff;
      rsp_drop_in  = rsp_drop_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_total_in = rsp_total_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               key_in     = req_tdata[KEY_W-1:0];
               idx_in     = '0;
               cmp_vld_in = 1'b0;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!done) begin
               // issue the next entry read
               cmp_vld_in = 1'b1;
               cmp_idx_in = idx_ff;
               idx_in     = idx_ff + CW'(1);
            end else if (commit) begin
               rsp_vld_in = 1'b1;
               state_in   = ST_DONE;
               if (hit) begin
                  rsp_new_in   = 1'b0;
                  rsp_drop_in  = 1'b0;
                  rsp_slot_in  = cmp_idx_x[SLOT_W-1:0];
                  rsp_cnt_in   = inc_cnt;
                  rsp_total_in = fill_x[SLOT_W-1:0];
               end else if (full) begin
                  rsp_new_in   = 1'b0;
                  rsp_drop_in  = 1'b1;
                  rsp_slot_in  = '0;
                  rsp_cnt_in   = '0;
                  rsp_total_in = fill_x[SLOT_W-1:0];
               end else begin
                  rsp_new_in   = 1'b1;
                  rsp_drop_in  = 1'b0;
                  rsp_slot_in  = fill_x[SLOT_W-1:0];
                  rsp_cnt_in   = COUNT_W'(1);
                  rsp_total_in = fill_inc_x[SLOT_W-1:0];
                  fill_in      = fill_ff + CW'(1);
               end
            end
         end
         ST_DONE: begin
            // table write has landed
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // table memory ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= table_mem[idx_ff[IW-1:0]];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         fill_ff    <= '0;
         cmp_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         fill_ff    <= fill_in;
         cmp_vld_ff <= cmp_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      idx_ff       <= idx_in;
      cmp_idx_ff   <= cmp_idx_in;
      rsp_new_ff   <= rsp_new_in;
      rsp_drop_ff  <= rsp_drop_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_cnt_ff   <= rsp_cnt_in;
      rsp_total_ff <= rsp_total_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {rsp_total_ff, rsp_cnt_ff, rsp_slot_ff};
   assign rsp_tuser  = {rsp_drop_ff, rsp_new_ff};

endmodule

`default_nettype wire
